// File: rtl/fpsf_pkg.sv
// Shared types and constants of the five-point stencil filter.
package fpsf_pkg;

	localparam int SIZE_W      = 11;
	localparam int WEIGHT_W    = 16;
	localparam int OUT_ROW_W   = 10;
	localparam int OUT_COL_W   = 10;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;
	localparam int FRAC_BITS   = 16;
	localparam int ROUND_HALF  = 32768;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_ROWS       = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_COLS       = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_WEIGHT    = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_NEIGHBOUR_WEIGHT = 4'd3;

	localparam logic [SIZE_W-1:0]   RST_IMAGE_ROWS       = 11'd1024;
	localparam logic [SIZE_W-1:0]   RST_IMAGE_COLS       = 11'd1024;
	localparam logic [WEIGHT_W-1:0] RST_CENTER_WEIGHT    = 16'd39322;
	localparam logic [WEIGHT_W-1:0] RST_NEIGHBOUR_WEIGHT = 16'd6554;

	typedef struct packed {
		logic [SIZE_W-1:0]   image_rows;
		logic [SIZE_W-1:0]   image_cols;
		logic [WEIGHT_W-1:0] center_weight;
		logic [WEIGHT_W-1:0] neighbour_weight;
	} cfg_t;

endpackage

// File: rtl/fpsf_if.sv
// Channel interfaces of the five-point stencil filter.
interface fpsf_pixel_if #(parameter int PIXEL_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [PIXEL_BITS-1:0] pixel_value;
	modport source (output valid, output kind, output pixel_value, input ready);
	modport sink (input valid, input kind, input pixel_value, output ready);
endinterface

interface fpsf_result_if #(parameter int PIXEL_BITS = 16);
	logic                            valid;
	logic                            ready;
	logic [PIXEL_BITS-1:0]           filtered_value;
	logic [fpsf_pkg::OUT_ROW_W-1:0]  out_row;
	logic [fpsf_pkg::OUT_COL_W-1:0]  out_col;
	logic                            last;
	modport source (output valid, output filtered_value, output out_row, output out_col,
		output last, input ready);
	modport sink (input valid, input filtered_value, input out_row, input out_col,
		input last, output ready);
endinterface

interface fpsf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fpsf_pkg::CFG_INDEX_W-1:0] index;
	logic [fpsf_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/five_point_stencil_filter_top.sv
// Top level of the five-point stencil filter: configuration registers and block wiring.
// Streams a column-major image one pixel per transaction and returns, for each pixel, the
// centre weight times the pixel plus the neighbour weight times the sum of its four
// neighbours (Q0.16 weights), rounded half up to a whole pixel and saturated. Sustained
// rate is one pixel per cycle while the job queue has room; the limit is the single write
// port of the two-column store, which takes one row word per pixel. A pixel's result is
// formed once the pixel to its right is accepted and leaves through the result register.
// No result comes out while column 0 streams in; after the last column send one column
// of flush transactions to drain the final column, whose last result carries last.
// Configuration writes are taken every cycle and must only be made while the block is
// idle. The column store is not cleared after reset and needs no initialisation pass.
module five_point_stencil_filter_top #(
	parameter int MAX_ROWS   = 1024,
	parameter int MAX_COLS   = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	fpsf_pixel_if.sink    pixels,
	fpsf_result_if.source results,
	fpsf_cfg_if.sink      cfg
);

	localparam int JOB_W = 2*PIXEL_BITS + 2 + fpsf_pkg::OUT_ROW_W + fpsf_pkg::OUT_COL_W + 1;

	fpsf_pkg::cfg_t   cfg_q;
	logic             push, q_full, q_not_empty, pop;
	logic [JOB_W-1:0] push_job, pop_job;

	// register writes are always accepted: ready is tied high
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_rows       <= fpsf_pkg::RST_IMAGE_ROWS;
			cfg_q.image_cols       <= fpsf_pkg::RST_IMAGE_COLS;
			cfg_q.center_weight    <= fpsf_pkg::RST_CENTER_WEIGHT;
			cfg_q.neighbour_weight <= fpsf_pkg::RST_NEIGHBOUR_WEIGHT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fpsf_pkg::CFG_IMAGE_ROWS:
					cfg_q.image_rows <= cfg.data[fpsf_pkg::SIZE_W-1:0];
				fpsf_pkg::CFG_IMAGE_COLS:
					cfg_q.image_cols <= cfg.data[fpsf_pkg::SIZE_W-1:0];
				fpsf_pkg::CFG_CENTER_WEIGHT:
					cfg_q.center_weight <= cfg.data;
				fpsf_pkg::CFG_NEIGHBOUR_WEIGHT:
					cfg_q.neighbour_weight <= cfg.data;
				default: ; // drop writes to unmapped indices
			endcase
		end
	end

	// front end: position tracking, column store and neighbour gathering
	fpsf_front #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.PIXEL_BITS (PIXEL_BITS),
		.JOB_W      (JOB_W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push),
		.job    (push_job)
	);

	// decouple the gather stage from the multiply pipeline
	fpsf_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_data  (pop_job)
	);

	// back end: two multiplies, rounding add, saturation, result register
	fpsf_back #(
		.PIXEL_BITS (PIXEL_BITS),
		.JOB_W      (JOB_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (q_not_empty),
		.job       (pop_job),
		.job_pop   (pop),
		.results   (results)
	);

endmodule

// File: rtl/fpsf_front.sv
// Front end: pixel acceptance, position tracking and the two-column store.
module fpsf_front #(
	parameter int MAX_ROWS   = 1024,
	parameter int MAX_COLS   = 1024,
	parameter int PIXEL_BITS = 16,
	parameter int JOB_W      = 2*PIXEL_BITS + 2 + fpsf_pkg::OUT_ROW_W + fpsf_pkg::OUT_COL_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	fpsf_pixel_if.sink        pixels,
	input  fpsf_pkg::cfg_t    cfg,
	input  logic              q_full,
	output logic              push,
	output logic [JOB_W-1:0]  job
);

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS + 1);
	localparam int P     = PIXEL_BITS;
	localparam int SUM_W = PIXEL_BITS + 2;
	localparam int OUT_COL_W_L = fpsf_pkg::OUT_COL_W;
	localparam logic [31:0] MAXR = 32'(MAX_ROWS);
	localparam logic [31:0] MAXC = 32'(MAX_COLS);

	// word layout: older column in the upper half, recent column in the lower
	logic [2*P-1:0] mem [MAX_ROWS];

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [P-1:0]     up_q;

	logic [31:0] rows32, cols32, raw_rows, raw_cols, r32, c32;
	logic        last_row, flush_col, accept, s1_leave;
	logic [ROW_W-1:0] addr0, addr1;
	logic [P-1:0]     incoming;

	logic                 v_s1, emit_s1, left_ok_s1, up_ok_s1, down_ok_s1, last_s1;
	logic                 byp0_s1, byp1_s1;
	logic [ROW_W-1:0]     r_s1;
	logic [OUT_COL_W_L-1:0] out_col_s1;
	logic [P-1:0]         incoming_s1, rd1_s1;
	logic [2*P-1:0]       rd0_s1, byp_word_s1;

	logic [2*P-1:0] word0, wr_word;
	logic [P-1:0]   center, left_px, up_px, down_px, down_raw;
	logic [SUM_W-1:0] nsum;

	// clamp sizes and resolve the current position
	always_comb begin
		raw_rows = 32'(cfg.image_rows);
		raw_cols = 32'(cfg.image_cols);
		rows32 = (raw_rows == 32'd0) ? 32'd1 : ((raw_rows > MAXR) ? MAXR : raw_rows);
		cols32 = (raw_cols == 32'd0) ? 32'd1 : ((raw_cols > MAXC) ? MAXC : raw_cols);
		r32 = (32'(row_q) >= rows32) ? 32'd0 : 32'(row_q);
		c32 = (32'(col_q) > cols32) ? 32'd0 : 32'(col_q);
		last_row  = (r32 + 32'd1) >= rows32;
		flush_col = (c32 == cols32);
		addr0 = ROW_W'(r32);
		addr1 = ROW_W'(r32 + 32'd1);
		incoming = (pixels.kind || flush_col) ? '0 : pixels.pixel_value;
	end

	assign s1_leave      = v_s1 && (!emit_s1 || !q_full);
	assign pixels.ready  = !v_s1 || s1_leave;
	assign accept        = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept) begin
				row_q <= last_row ? '0 : ROW_W'(r32 + 32'd1);
				if (last_row)
					col_q <= (c32 >= cols32) ? '0 : COL_W'(c32 + 32'd1);
				else
					col_q <= COL_W'(c32);
				v_s1 <= 1'b1;
			end else if (s1_leave) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// stage 1 payload; forward the write that lands on the accepting edge
	always_ff @(posedge clk) begin
		if (accept) begin
			r_s1        <= addr0;
			emit_s1     <= (c32 != 32'd0);
			left_ok_s1  <= (c32 >= 32'd2);
			up_ok_s1    <= (r32 != 32'd0);
			down_ok_s1  <= !last_row;
			last_s1     <= flush_col && last_row;
			out_col_s1  <= OUT_COL_W_L'(c32 - 32'd1);
			incoming_s1 <= incoming;
			rd0_s1      <= mem[addr0];
			rd1_s1      <= mem[addr1][P-1:0];
			byp0_s1     <= s1_leave && (r_s1 == addr0);
			byp1_s1     <= s1_leave && (r_s1 == addr1);
			byp_word_s1 <= wr_word;
		end
		if (s1_leave) begin
			mem[r_s1] <= wr_word;
			up_q      <= center;
		end
	end

	always_comb begin
		word0    = byp0_s1 ? byp_word_s1 : rd0_s1;
		down_raw = byp1_s1 ? byp_word_s1[P-1:0] : rd1_s1;
		center   = word0[P-1:0];
		left_px  = left_ok_s1 ? word0[2*P-1:P] : '0;
		up_px    = up_ok_s1 ? up_q : '0;
		down_px  = down_ok_s1 ? down_raw : '0;
		nsum     = SUM_W'(left_px) + SUM_W'(up_px) + SUM_W'(down_px) + SUM_W'(incoming_s1);
		wr_word  = {center, incoming_s1};
	end

	assign push = s1_leave && emit_s1;
	assign job  = {center, nsum, fpsf_pkg::OUT_ROW_W'(r_s1), out_col_s1, last_s1};

endmodule

// File: rtl/fpsf_queue.sv
// Short job queue between the front end and the arithmetic back end.
module fpsf_queue #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int DEPTH = fpsf_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				tail_q <= (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			if (pop)
				head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[tail_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(DEPTH)))
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("job popped from an empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count failed to advance on push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count failed to drop on pop");

endmodule

// File: rtl/fpsf_back.sv
// Back end: weighted sum, rounding, saturation and the result register.
module fpsf_back #(
	parameter int PIXEL_BITS = 16,
	parameter int JOB_W      = 2*PIXEL_BITS + 2 + fpsf_pkg::OUT_ROW_W + fpsf_pkg::OUT_COL_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fpsf_pkg::cfg_t   cfg,
	input  logic             job_valid,
	input  logic [JOB_W-1:0] job,
	output logic             job_pop,
	fpsf_result_if.source    results
);

	localparam int P     = PIXEL_BITS;
	localparam int SUM_W = PIXEL_BITS + 2;
	localparam int PC_W  = fpsf_pkg::WEIGHT_W + P;
	localparam int PN_W  = fpsf_pkg::WEIGHT_W + SUM_W;
	localparam int ACC_W = PN_W + 1;
	localparam int RES_W = ACC_W - fpsf_pkg::FRAC_BITS;
	localparam int ROW_W = fpsf_pkg::OUT_ROW_W;
	localparam int COL_W = fpsf_pkg::OUT_COL_W;

	logic [P-1:0]     j_center;
	logic [SUM_W-1:0] j_nsum;
	logic [ROW_W-1:0] j_row;
	logic [COL_W-1:0] j_col;
	logic             j_last;

	logic             v_s2, last_s2;
	logic [PC_W-1:0]  pc_s2;
	logic [PN_W-1:0]  pn_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;

	logic             v_s3, last_s3;
	logic [P-1:0]     value_s3;
	logic [ROW_W-1:0] row_s3;
	logic [COL_W-1:0] col_s3;

	logic             adv2, adv3;
	logic [ACC_W-1:0] acc;
	logic [RES_W-1:0] res;
	logic [P-1:0]     sat;

	assign {j_center, j_nsum, j_row, j_col, j_last} = job;

	assign adv3    = !v_s3 || results.ready;
	assign adv2    = !v_s2 || adv3;
	assign job_pop = job_valid && adv2;

	always_comb begin
		acc = ACC_W'(pc_s2) + ACC_W'(pn_s2) + ACC_W'(fpsf_pkg::ROUND_HALF);
		res = acc[ACC_W-1:fpsf_pkg::FRAC_BITS];
		sat = (|res[RES_W-1:P]) ? '1 : res[P-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv2)
				v_s2 <= job_valid;
			if (adv3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			pc_s2   <= PC_W'(cfg.center_weight) * PC_W'(j_center);
			pn_s2   <= PN_W'(cfg.neighbour_weight) * PN_W'(j_nsum);
			row_s2  <= j_row;
			col_s2  <= j_col;
			last_s2 <= j_last;
		end
		if (adv3 && v_s2) begin
			value_s3 <= sat;
			row_s3   <= row_s2;
			col_s3   <= col_s2;
			last_s3  <= last_s2;
		end
	end

	assign results.valid          = v_s3;
	assign results.filtered_value = value_s3;
	assign results.out_row        = row_s3;
	assign results.out_col        = col_s3;
	assign results.last           = last_s3;

endmodule

// File: tb/five_point_stencil_filter_top_tb.sv
// Self-checking testbench of the five-point stencil filter top level.
module five_point_stencil_filter_top_tb;

	localparam int MAX_ROWS      = 1024;
	localparam int MAX_COLS      = 1024;
	localparam int PIXEL_BITS    = 16;
	localparam int RESET_FEED    = 8;
	localparam int RANDOM_ITEMS  = 500;
	// Pixels still in flight when the last result leaves: a column 0 pixel
	// causes no result but is still being written into the column store.
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 200000;

	typedef enum logic {PIX_REAL = 1'b0, PIX_FLUSH = 1'b1} pixel_kind_e;
	typedef enum logic {ROW_WRITE = 1'b0, ROW_PIXEL = 1'b1} row_op_e;

	typedef struct packed {
		logic [PIXEL_BITS-1:0]          value;
		logic [fpsf_pkg::OUT_ROW_W-1:0] row;
		logic [fpsf_pkg::OUT_COL_W-1:0] col;
		logic                           last;
	} filtered_pixel_t;

	// One line of the directed table: either a register write or a pixel.
	// A typed value replaces the predicted filtered value of the result that
	// the pixel releases.
	typedef struct packed {
		row_op_e                          op;
		logic [fpsf_pkg::CFG_INDEX_W-1:0] index;
		pixel_kind_e                      kind;
		logic [fpsf_pkg::CFG_DATA_W-1:0]  data;
		logic                             typed;
		logic [PIXEL_BITS-1:0]            want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	fpsf_pixel_if #(.PIXEL_BITS(PIXEL_BITS)) pix_ch ();
	fpsf_result_if #(.PIXEL_BITS(PIXEL_BITS)) res_ch ();
	fpsf_cfg_if cfg_ch ();

	five_point_stencil_filter_top #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.PIXEL_BITS(PIXEL_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_ch),
		.results(res_ch),
		.cfg    (cfg_ch)
	);

	// Shadow of the configuration registers, as written
	logic [fpsf_pkg::SIZE_W-1:0]   rows_reg;
	logic [fpsf_pkg::SIZE_W-1:0]   cols_reg;
	logic [fpsf_pkg::WEIGHT_W-1:0] cw_reg;
	logic [fpsf_pkg::WEIGHT_W-1:0] nw_reg;

	// Shadow of the block state: two previous columns and the scan position
	logic [PIXEL_BITS-1:0] two_back [MAX_ROWS];
	logic [PIXEL_BITS-1:0] one_back [MAX_ROWS];
	int unsigned           row_at;
	int unsigned           col_at;

	filtered_pixel_t filtered_q [$];

	int unsigned cycle_count     = 0;
	int unsigned mismatches      = 0;
	int unsigned results_checked = 0;
	int unsigned pixels_sent     = 0;
	int unsigned reg_writes      = 0;
	int unsigned burst_left      = 0;
	int unsigned stall_tick      = 0;
	int unsigned stall_mode      = 0;

	// Directed part. It follows a short feed at reset size that leaves the row
	// position beyond the first row count written, so that row count restarts it.
	stim_row_t directed_rows [$] = '{
		// Rows shrink while column 0 is half in: the row position restarts at 0
		'{ROW_WRITE, fpsf_pkg::CFG_IMAGE_COLS, PIX_REAL, 16'd1, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_IMAGE_ROWS, PIX_REAL, 16'd5, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'h0F0F, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'hF0F0, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'h5A5A, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_IMAGE_ROWS, PIX_REAL, 16'd2, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'h0080, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'h7FFF, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_FLUSH, 16'h0000, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_FLUSH, 16'h0000, 1'b0, 16'd0},
		// Full-scale weights and pixels: every result saturates
		'{ROW_WRITE, fpsf_pkg::CFG_IMAGE_ROWS, PIX_REAL, 16'd2, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_IMAGE_COLS, PIX_REAL, 16'd2, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_CENTER_WEIGHT, PIX_REAL, 16'hFFFF, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_NEIGHBOUR_WEIGHT, PIX_REAL, 16'hFFFF, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'hFFFF, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'hFFFF, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'hFFFF, 1'b1, 16'hFFFF},
		'{ROW_PIXEL, '0, PIX_REAL, 16'hFFFF, 1'b1, 16'hFFFF},
		'{ROW_PIXEL, '0, PIX_FLUSH, 16'hFFFF, 1'b1, 16'hFFFF},
		'{ROW_PIXEL, '0, PIX_FLUSH, 16'hFFFF, 1'b1, 16'hFFFF},
		// Zero weights, zero sizes taken as a 1x1 image
		'{ROW_WRITE, fpsf_pkg::CFG_CENTER_WEIGHT, PIX_REAL, 16'h0000, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_NEIGHBOUR_WEIGHT, PIX_REAL, 16'h0000, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_IMAGE_ROWS, PIX_REAL, 16'd0, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_IMAGE_COLS, PIX_REAL, 16'd0, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'h1234, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_FLUSH, 16'h0000, 1'b1, 16'h0000},
		// Flush inside the image, real pixel inside the flush column
		'{ROW_WRITE, fpsf_pkg::CFG_CENTER_WEIGHT, PIX_REAL, 16'h8000, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_NEIGHBOUR_WEIGHT, PIX_REAL, 16'h4000, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_IMAGE_ROWS, PIX_REAL, 16'd3, 1'b0, 16'd0},
		'{ROW_WRITE, fpsf_pkg::CFG_IMAGE_COLS, PIX_REAL, 16'd2, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'h0100, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_FLUSH, 16'h0000, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'hFFFF, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'h0001, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'h8000, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'h00FF, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_REAL, 16'hABCD, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_FLUSH, 16'h0000, 1'b0, 16'd0},
		'{ROW_PIXEL, '0, PIX_FLUSH, 16'h0000, 1'b0, 16'd0}
	};

	// Clamp a size register to the range the block works with
	function automatic int unsigned eff_size(input int unsigned v, input int unsigned max);
		if (v < 1) return 1;
		if (v > max) return max;
		return v;
	endfunction

	// Advance the shadow state by one pixel; return 1 and the filtered pixel
	// that this pixel releases, if any.
	function automatic bit predict_stencil(input pixel_kind_e kind,
		input logic [PIXEL_BITS-1:0] value, output filtered_pixel_t res);
		int unsigned           rows;
		int unsigned           cols;
		int unsigned           r;
		int unsigned           c;
		logic [PIXEL_BITS-1:0] incoming;
		logic [PIXEL_BITS-1:0] centre;
		logic [PIXEL_BITS-1:0] left_px;
		logic [PIXEL_BITS-1:0] up_px;
		logic [PIXEL_BITS-1:0] down_px;
		logic [39:0]           acc;
		logic [39:0]           rounded;
		bit                    produced;
		rows = eff_size(rows_reg, MAX_ROWS);
		cols = eff_size(cols_reg, MAX_COLS);
		produced = 1'b0;
		res = '0;
		// Sizes shrunk under a running image: restart the position
		if (row_at >= rows) row_at = 0;
		if (col_at > cols) col_at = 0;
		r = row_at;
		c = col_at;
		incoming = (kind == PIX_FLUSH || c == cols) ? '0 : value;
		if (c >= 1) begin
			// The pixel above was already shifted into two_back this column
			centre  = one_back[r];
			left_px = (c >= 2) ? two_back[r] : '0;
			up_px   = (r > 0) ? two_back[r - 1] : '0;
			down_px = (r + 1 < rows) ? one_back[r + 1] : '0;
			acc = 40'(cw_reg) * 40'(centre) + 40'(nw_reg) *
				(40'(left_px) + 40'(up_px) + 40'(down_px) + 40'(incoming));
			rounded = (acc + 40'(fpsf_pkg::ROUND_HALF)) >> fpsf_pkg::FRAC_BITS;
			res.value = (rounded > 40'({PIXEL_BITS{1'b1}})) ? {PIXEL_BITS{1'b1}}
				: rounded[PIXEL_BITS-1:0];
			res.row  = r[fpsf_pkg::OUT_ROW_W-1:0];
			res.col  = fpsf_pkg::OUT_COL_W'(c - 1);
			res.last = (c == cols && r + 1 == rows);
			produced = 1'b1;
		end
		two_back[r] = one_back[r];
		one_back[r] = incoming;
		if (r + 1 >= rows) begin
			row_at = 0;
			col_at = (c >= cols) ? 0 : c + 1;
		end else begin
			row_at = r + 1;
		end
		return produced;
	endfunction

	function automatic logic [PIXEL_BITS-1:0] pixel_choice();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return PIXEL_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [fpsf_pkg::WEIGHT_W-1:0] weight_choice(
		input logic [fpsf_pkg::WEIGHT_W-1:0] typical);
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return typical;
			default: return fpsf_pkg::WEIGHT_W'($urandom);
		endcase
	endfunction

	// Offer one pixel, in bursts with random gaps, and book its result
	task automatic send_pixel(input pixel_kind_e kind, input logic [PIXEL_BITS-1:0] value,
		input logic typed, input logic [PIXEL_BITS-1:0] want);
		filtered_pixel_t expected;
		if (burst_left == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 12);
		end
		burst_left--;
		pix_ch.valid       <= 1'b1;
		pix_ch.kind        <= kind;
		pix_ch.pixel_value <= value;
		do @(posedge clk); while (!pix_ch.ready);
		pixels_sent++;
		if (predict_stencil(kind, value, expected)) begin
			if (typed) expected.value = want;
			filtered_q.push_back(expected);
		end
	endtask

	// Write one register; leave a bubble so the valid drop never meets a raise
	task automatic write_reg(input logic [fpsf_pkg::CFG_INDEX_W-1:0] index,
		input logic [fpsf_pkg::CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		reg_writes++;
		case (index)
			fpsf_pkg::CFG_IMAGE_ROWS:       rows_reg = data[fpsf_pkg::SIZE_W-1:0];
			fpsf_pkg::CFG_IMAGE_COLS:       cols_reg = data[fpsf_pkg::SIZE_W-1:0];
			fpsf_pkg::CFG_CENTER_WEIGHT:    cw_reg   = data[fpsf_pkg::WEIGHT_W-1:0];
			fpsf_pkg::CFG_NEIGHBOUR_WEIGHT: nw_reg   = data[fpsf_pkg::WEIGHT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Hold the pixel channel until every booked result is back, then settle
	task automatic wait_for_idle();
		pix_ch.valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: at regular intervals, pick at random between always ready,
	// random stalls and a fixed stall pattern.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			stall_tick++;
			if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0:       res_ch.ready <= 1'b1;
				1:       res_ch.ready <= ($urandom_range(0, 9) < 6);
				default: res_ch.ready <= (stall_tick % 32 < 19);
			endcase
		end
	end

	// Compare each filtered pixel, field by field, with the oldest booked one
	always @(posedge clk) begin
		filtered_pixel_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected result: value %h row %0d col %0d last %b", $time,
					res_ch.filtered_value, res_ch.out_row, res_ch.out_col, res_ch.last);
				mismatches++;
			end else begin
				want = filtered_q.pop_front();
				results_checked++;
				if (res_ch.filtered_value !== want.value) begin
					$display("%0t: filtered_value expected %h actual %h", $time, want.value,
						res_ch.filtered_value);
					mismatches++;
				end
				if (res_ch.out_row !== want.row) begin
					$display("%0t: out_row expected %0d actual %0d", $time, want.row,
						res_ch.out_row);
					mismatches++;
				end
				if (res_ch.out_col !== want.col) begin
					$display("%0t: out_col expected %0d actual %0d", $time, want.col,
						res_ch.out_col);
					mismatches++;
				end
				if (res_ch.last !== want.last) begin
					$display("%0t: last expected %b actual %b", $time, want.last,
						res_ch.last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: stop a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, filtered_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		int unsigned c;
		int unsigned rows_now;
		int unsigned cols_now;
		int unsigned stop_col;
		int unsigned new_rows;
		int unsigned new_cols;
		int unsigned random_items;
		bit          tidy;
		bit          need_drain;
		pixel_kind_e kind;

		// Drive every input to a known level before the first edge
		arst_n             <= 1'b0;
		pix_ch.valid       <= 1'b0;
		pix_ch.kind        <= 1'b0;
		pix_ch.pixel_value <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= '0;
		cfg_ch.data        <= '0;

		rows_reg = fpsf_pkg::RST_IMAGE_ROWS;
		cols_reg = fpsf_pkg::RST_IMAGE_COLS;
		cw_reg   = fpsf_pkg::RST_CENTER_WEIGHT;
		nw_reg   = fpsf_pkg::RST_NEIGHBOUR_WEIGHT;
		row_at   = 0;
		col_at   = 0;
		foreach (two_back[i]) begin
			two_back[i] = '0;
			one_back[i] = '0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes and weights: the first rows of column 0 of the default
		// image, which releases no result and leaves the row position raised
		for (r = 0; r < RESET_FEED; r++) send_pixel(PIX_REAL, pixel_choice(), 1'b0, '0);

		// Walk the directed table; drain before each group of writes
		need_drain = 1'b1;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == ROW_WRITE) begin
				if (need_drain) wait_for_idle();
				need_drain = 1'b0;
				write_reg(directed_rows[i].index, directed_rows[i].data);
			end else begin
				send_pixel(directed_rows[i].kind, directed_rows[i].data[PIXEL_BITS-1:0],
					directed_rows[i].typed, directed_rows[i].want);
				need_drain = 1'b1;
			end
		end

		// Random images: mostly well formed, some with stray kinds, some
		// abandoned at a column boundary and cut short by a smaller column count
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (col_at != 0 || $urandom_range(0, 2) != 0) begin
				wait_for_idle();
				new_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
					: $urandom_range(1, 6);
				if (col_at != 0) new_cols = $urandom_range(1, col_at - 1);
				else new_cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24)
					: $urandom_range(1, 6);
				// Upper data bits are outside the size field and must be dropped
				write_reg(fpsf_pkg::CFG_IMAGE_ROWS,
					{5'($urandom), fpsf_pkg::SIZE_W'(new_rows)});
				write_reg(fpsf_pkg::CFG_IMAGE_COLS,
					{5'($urandom), fpsf_pkg::SIZE_W'(new_cols)});
				write_reg(fpsf_pkg::CFG_CENTER_WEIGHT,
					weight_choice(fpsf_pkg::RST_CENTER_WEIGHT));
				write_reg(fpsf_pkg::CFG_NEIGHBOUR_WEIGHT,
					weight_choice(fpsf_pkg::RST_NEIGHBOUR_WEIGHT));
			end
			rows_now = eff_size(rows_reg, MAX_ROWS);
			cols_now = eff_size(cols_reg, MAX_COLS);
			stop_col = (cols_now >= 2 && $urandom_range(0, 9) == 0)
				? $urandom_range(2, cols_now) : cols_now + 1;
			tidy = ($urandom_range(0, 3) != 0);
			for (c = 0; c <= cols_now && c < stop_col; c++) begin
				for (r = 0; r < rows_now; r++) begin
					if (c < cols_now)
						kind = (!tidy && $urandom_range(0, 7) == 0) ? PIX_FLUSH : PIX_REAL;
					else
						kind = (!tidy && $urandom_range(0, 3) == 0) ? PIX_REAL : PIX_FLUSH;
					send_pixel(kind, pixel_choice(), 1'b0, '0);
					random_items++;
				end
			end
		end

		wait_for_idle();
		$display("Run covered %0d pixels, %0d register writes and %0d checked results",
			pixels_sent, reg_writes, results_checked);
		$display("Images from 1x1 up to 40 rows and 24 columns, with saturation, "
			, "stray flush kinds, zero sizes and mid-image restarts");
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
